/* rtl/core/clt_pkg.sv */
// Shared constants, types and event codes of the client liveness tracker.
package clt_pkg;

  localparam int MAX_CLIENTS = 64;
  localparam int IDX_W       = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

  localparam int ADDR_W  = 32;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 7;
  localparam int KIND_W  = 3;
  localparam int EXP_W   = 11;
  localparam int NCNT_W  = 2;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 32;

  localparam int SEC_PER_MIN = 60;
  localparam int LIMIT_W     = $clog2(((2 ** EXP_W) - 1) * SEC_PER_MIN + 1);

  localparam int EXPIRE_RESET = 60;

  typedef enum logic [KIND_W-1:0] {
    EV_REFRESHED = 3'd0,
    EV_ADDED     = 3'd1,
    EV_FULL      = 3'd2,
    EV_OUTSIDE   = 3'd3,
    EV_DOWN      = 3'd4,
    EV_BACK      = 3'd5
  } ev_kind_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_EXPIRE      = 3'd0,
    CFG_MAX_CLIENTS = 3'd1,
    CFG_NET_COUNT   = 3'd2,
    CFG_NET0_BASE   = 3'd3,
    CFG_NET0_MASK   = 3'd4,
    CFG_NET1_BASE   = 3'd5,
    CFG_NET1_MASK   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic [CNT_W-1:0]   table_limit;
    logic [NCNT_W-1:0]  net_cnt;
    logic [ADDR_W-1:0]  net0_base;
    logic [ADDR_W-1:0]  net0_mask;
    logic [ADDR_W-1:0]  net1_base;
    logic [ADDR_W-1:0]  net1_mask;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] seen;
    logic              down;
  } entry_t;

  typedef struct packed {
    ev_kind_e          kind;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] seen;
    logic [CNT_W-1:0]  down_total;
    logic [CNT_W-1:0]  tracked_total;
  } result_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic refresh;
    logic append;
    logic full;
    logic outside;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic scan;
    logic accepted;
    logic hit;
    logic rvalid;
    logic rd_more;
    logic scan_ev;
    logic pend_valid;
    logic out_free;
    logic room;
  } status_t;

endpackage

/* rtl/core/clt_if.sv */
// Handshake channel interfaces: input items, result words and configuration writes.
interface clt_req_if import clt_pkg::*;;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] host_addr;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, mode, host_addr, now_time, input ready);
  modport sink (input valid, mode, host_addr, now_time, output ready);
endinterface

interface clt_evt_if import clt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [ADDR_W-1:0] event_addr;
  logic [TIME_W-1:0] last_seen;
  logic [CNT_W-1:0]  down_total;
  logic [CNT_W-1:0]  tracked_total;
  logic              last;

  modport source (output valid, event_kind, event_addr, last_seen, down_total,
                  tracked_total, last, input ready);
  modport sink (input valid, event_kind, event_addr, last_seen, down_total,
                tracked_total, last, output ready);
endinterface

interface clt_cfg_if import clt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/clt_cfg.sv */
// Configuration register file with derived expiry limit and table limit.
module clt_cfg import clt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  clt_cfg_if.sink cfg_i,
  output cfg_t  cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic [CNT_W-1:0] clients_w;

  assign cfg_i.ready = 1'b1;
  assign clients_w   = cfg_i.data[CNT_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_EXPIRE: begin
          cfg_d.limit = LIMIT_W'({{(LIMIT_W-EXP_W){1'b0}}, cfg_i.data[EXP_W-1:0]}
                                 * LIMIT_W'(SEC_PER_MIN));
        end
        CFG_MAX_CLIENTS: begin
          // cap at the physical table depth
          cfg_d.table_limit = (clients_w > CNT_W'(MAX_CLIENTS)) ? CNT_W'(MAX_CLIENTS)
                                                                : clients_w;
        end
        CFG_NET_COUNT: begin
          cfg_d.net_cnt = (cfg_i.data[NCNT_W-1:0] == 2'd3) ? 2'd2
                                                           : cfg_i.data[NCNT_W-1:0];
        end
        CFG_NET0_BASE: cfg_d.net0_base = cfg_i.data[ADDR_W-1:0];
        CFG_NET0_MASK: cfg_d.net0_mask = cfg_i.data[ADDR_W-1:0];
        CFG_NET1_BASE: cfg_d.net1_base = cfg_i.data[ADDR_W-1:0];
        CFG_NET1_MASK: cfg_d.net1_mask = cfg_i.data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit       <= LIMIT_W'(EXPIRE_RESET * SEC_PER_MIN);
      cfg_q.table_limit <= CNT_W'(MAX_CLIENTS);
      cfg_q.net_cnt     <= '0;
      cfg_q.net0_base   <= '0;
      cfg_q.net0_mask   <= '0;
      cfg_q.net1_base   <= '0;
      cfg_q.net1_mask   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/clt_dp.sv */
// Datapath: host table memory, walk pointer, counters, pending word and output register.
module clt_dp import clt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              mode_i,
  input  logic [ADDR_W-1:0] host_addr_i,
  input  logic [TIME_W-1:0] now_time_i,
  input  cmd_t              cmd_i,
  output status_t           st_o,
  clt_evt_if.source         out_o
);

  entry_t mem_q [MAX_CLIENTS];

  logic              mode_q;
  logic [ADDR_W-1:0] addr_q;
  logic [TIME_W-1:0] now_q;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              rvalid_q, rvalid_d;
  logic [IDX_W-1:0]  ridx_q;
  entry_t            rdata_q;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  down_q, down_d;
  logic              pend_valid_q, pend_valid_d;
  result_t           pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;
  logic              out_last_q, out_last_d;

  logic              rd_en;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  logic [TIME_W-1:0] diff;
  logic              expired;
  logic              scan_ev;
  logic              scan_take;
  logic              ev_set;
  result_t           ev_new;
  logic [CNT_W-1:0]  down_next;
  logic              accepted;
  logic              m0, m1;
  logic              out_free;
  logic              out_push;

  assign m0 = (addr_q & cfg_i.net0_mask) == (cfg_i.net0_base & cfg_i.net0_mask);
  assign m1 = (addr_q & cfg_i.net1_mask) == (cfg_i.net1_base & cfg_i.net1_mask);

  always_comb begin
    case (cfg_i.net_cnt)
      2'd0:    accepted = 1'b1;
      2'd1:    accepted = m0;
      default: accepted = m0 || m1;
    endcase
  end

  assign diff      = now_q - rdata_q.seen;
  assign expired   = diff >= {{(TIME_W-LIMIT_W){1'b0}}, cfg_i.limit};
  assign scan_ev   = rvalid_q && mode_q && (rdata_q.down ? !expired : expired);
  assign scan_take = cmd_i.walk && scan_ev;
  assign down_next = rdata_q.down ? ((down_q == '0) ? '0 : down_q - 1'b1)
                                  : down_q + 1'b1;

  assign out_free = !out_valid_q || out_o.ready;
  assign rd_en    = cmd_i.walk && (rd_idx_q < used_q);

  // table write port
  always_comb begin
    we    = 1'b0;
    waddr = ridx_q;
    wdata = rdata_q;
    if (cmd_i.refresh) begin
      we         = 1'b1;
      wdata.seen = now_q;
    end else if (cmd_i.append) begin
      we    = 1'b1;
      waddr = used_q[IDX_W-1:0];
      wdata = '{addr: addr_q, seen: now_q, down: 1'b0};
    end else if (scan_take) begin
      we         = 1'b1;
      wdata.down = !rdata_q.down;
    end
  end

  // new event word for the pending slot
  always_comb begin
    ev_set = 1'b1;
    ev_new = '{kind: EV_OUTSIDE, addr: addr_q, seen: '0, down_total: down_q,
               tracked_total: used_q};
    if (cmd_i.refresh) begin
      ev_new.kind = EV_REFRESHED;
      ev_new.seen = now_q;
    end else if (cmd_i.append) begin
      ev_new.kind          = EV_ADDED;
      ev_new.seen          = now_q;
      ev_new.tracked_total = used_q + 1'b1;
    end else if (cmd_i.full) begin
      ev_new.kind = EV_FULL;
    end else if (cmd_i.outside) begin
      ev_new.kind = EV_OUTSIDE;
    end else if (scan_take) begin
      ev_new.kind       = rdata_q.down ? EV_BACK : EV_DOWN;
      ev_new.addr       = rdata_q.addr;
      ev_new.seen       = rdata_q.seen;
      ev_new.down_total = down_next;
    end else begin
      ev_set = 1'b0;
    end
  end

  always_comb begin
    rd_idx_d     = rd_idx_q;
    rvalid_d     = rvalid_q;
    used_d       = used_q;
    down_d       = down_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_push     = 1'b0;
    out_d        = out_q;
    out_last_d   = out_last_q;

    if (cmd_i.load) begin
      rd_idx_d = '0;
      rvalid_d = 1'b0;
    end
    if (cmd_i.walk) begin
      rvalid_d = rd_en;
      if (rd_en) rd_idx_d = rd_idx_q + 1'b1;
    end
    if (cmd_i.append) used_d = used_q + 1'b1;
    if (scan_take)    down_d = down_next;

    // move the older word out before the new one takes the slot
    if (cmd_i.flush) begin
      out_push     = 1'b1;
      out_d        = pend_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end else if (ev_set && pend_valid_q) begin
      out_push   = 1'b1;
      out_d      = pend_q;
      out_last_d = 1'b0;
    end
    if (ev_set) begin
      pend_valid_d = 1'b1;
      pend_d       = ev_new;
    end

    out_valid_d = out_push || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx_q[IDX_W-1:0]];
      ridx_q  <= rd_idx_q[IDX_W-1:0];
    end
    if (cmd_i.load) begin
      mode_q <= mode_i;
      addr_q <= host_addr_i;
      now_q  <= now_time_i;
    end
    if (ev_set) pend_q <= pend_d;
    if (out_push) begin
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q     <= '0;
      rvalid_q     <= 1'b0;
      used_q       <= '0;
      down_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_idx_q     <= rd_idx_d;
      rvalid_q     <= rvalid_d;
      used_q       <= used_d;
      down_q       <= down_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign st_o.scan       = mode_q;
  assign st_o.accepted   = accepted;
  assign st_o.hit        = rvalid_q && !mode_q && (rdata_q.addr == addr_q);
  assign st_o.rvalid     = rvalid_q;
  assign st_o.rd_more    = rd_idx_q < used_q;
  assign st_o.scan_ev    = scan_ev;
  assign st_o.pend_valid = pend_valid_q;
  assign st_o.out_free   = out_free;
  assign st_o.room       = used_q < cfg_i.table_limit;

  assign out_o.valid         = out_valid_q;
  assign out_o.event_kind    = out_q.kind;
  assign out_o.event_addr    = out_q.addr;
  assign out_o.last_seen     = out_q.seen;
  assign out_o.down_total    = out_q.down_total;
  assign out_o.tracked_total = out_q.tracked_total;
  assign out_o.last          = out_last_q;

endmodule

/* rtl/core/clt_ctrl.sv */
// Controller: sequences the network check, the table walk and the final word.
module clt_ctrl import clt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   walk_done;

  assign walk_done  = !st_i.rvalid && !st_i.rd_more;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!st_i.scan && !st_i.accepted) begin
          cmd_o.outside = 1'b1;
          state_d       = S_FLUSH;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (!st_i.scan) begin
          if (st_i.hit) begin
            cmd_o.refresh = 1'b1;
            state_d       = S_FLUSH;
          end else if (walk_done) begin
            cmd_o.append = st_i.room;
            cmd_o.full   = !st_i.room;
            state_d      = S_FLUSH;
          end else begin
            cmd_o.walk = 1'b1;
          end
        end else if (walk_done) begin
          state_d = st_i.pend_valid ? S_FLUSH : S_IDLE;
        end else if (!(st_i.scan_ev && st_i.pend_valid && !st_i.out_free)) begin
          // hold while a change is found and both the pending slot and the output register are full
          cmd_o.walk = 1'b1;
        end
      end
      S_FLUSH: begin
        if (st_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/client_liveness_tracker.sv */
// A report reads one table entry per cycle and gives its word on a hit, at the end of
// the table, or, outside the networks, without a walk; a scan gives each change word
// once the next change is found, and the last once the walk ends. One item at a time:
// the next is taken the cycle after the last word is loaded into the output register,
// or once the walk ends when a scan found no change.
// Reset: host and down counts clear, config takes its defaults, table stays undefined.
module client_liveness_tracker import clt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  clt_req_if.sink   in_i,
  clt_evt_if.source out_o,
  clt_cfg_if.sink   cfg_i
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  assign in_i.ready = in_ready;

  clt_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  clt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  clt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .mode_i      (in_i.mode),
    .host_addr_i (in_i.host_addr),
    .now_time_i  (in_i.now_time),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  a_flush_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |-> st.out_free)
    else $error("final word pushed into a full output register");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.refresh, cmd.append, cmd.full, cmd.outside, cmd.flush}))
    else $error("more than one event command in a cycle");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !st.pend_valid)
    else $error("idle with a word still pending");

  a_walk_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.walk && st.scan_ev && st.pend_valid) |-> st.out_free)
    else $error("scan change taken with no room for the pending word");
`endif

endmodule

/* tb/client_liveness_tracker_tb.sv */
// Testbench for the client liveness tracker: directed and random items with a scoreboard.
module client_liveness_tracker_tb import clt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = MAX_CLIENTS + 36;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_ITEMS   = 260;
  localparam int PHASES         = 6;

  typedef struct {
    ev_kind_e          kind;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] seen;
    logic [CNT_W-1:0]  down_total;
    logic [CNT_W-1:0]  tracked_total;
    logic              last;
  } event_word_t;

  class liveness_scoreboard;
    logic [ADDR_W-1:0] entry_addr [MAX_CLIENTS];
    logic [TIME_W-1:0] entry_seen [MAX_CLIENTS];
    bit                entry_down [MAX_CLIENTS];
    logic [CNT_W-1:0]  used_cnt;
    logic [CNT_W-1:0]  down_cnt;
    logic [EXP_W-1:0]  expire_min;
    logic [CNT_W-1:0]  max_clients;
    logic [NCNT_W-1:0] net_cnt;
    logic [ADDR_W-1:0] net_base [2];
    logic [ADDR_W-1:0] net_mask [2];
    event_word_t       expected_events [$];
    int unsigned       fail_count;

    function new();
      used_cnt    = '0;
      down_cnt    = '0;
      expire_min  = EXPIRE_RESET;
      max_clients = MAX_CLIENTS;
      net_cnt     = '0;
      for (int k = 0; k < 2; k++) begin
        net_base[k] = '0;
        net_mask[k] = '0;
      end
      fail_count = 0;
    endfunction

    function void note_config(cfg_idx_e idx, logic [CDATA_W-1:0] data);
      case (idx)
        CFG_EXPIRE:      expire_min  = data[EXP_W-1:0];
        CFG_MAX_CLIENTS: max_clients = data[CNT_W-1:0];
        CFG_NET_COUNT:   net_cnt     = data[NCNT_W-1:0];
        CFG_NET0_BASE:   net_base[0] = data[ADDR_W-1:0];
        CFG_NET0_MASK:   net_mask[0] = data[ADDR_W-1:0];
        CFG_NET1_BASE:   net_base[1] = data[ADDR_W-1:0];
        CFG_NET1_MASK:   net_mask[1] = data[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    function event_word_t make_event(ev_kind_e kind, logic [ADDR_W-1:0] addr,
                                     logic [TIME_W-1:0] seen);
      event_word_t w;
      w.kind          = kind;
      w.addr          = addr;
      w.seen          = seen;
      w.down_total    = down_cnt;
      w.tracked_total = used_cnt;
      w.last          = 1'b0;
      return w;
    endfunction

    // Work out the event words one input word causes and queue them.
    function void note_item(logic mode, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now);
      event_word_t       batch [$];
      int                tbl_lim;
      int                slot;
      bit                allowed;
      logic [TIME_W-1:0] limit;
      logic [TIME_W-1:0] diff;
      tbl_lim = (max_clients > MAX_CLIENTS) ? MAX_CLIENTS : int'(max_clients);
      limit   = TIME_W'(expire_min) * TIME_W'(SEC_PER_MIN);
      if (mode == 1'b0) begin
        // a count of three acts as two
        allowed = (net_cnt == 0) ||
                  ((addr & net_mask[0]) == (net_base[0] & net_mask[0])) ||
                  (net_cnt >= 2 && ((addr & net_mask[1]) == (net_base[1] & net_mask[1])));
        slot = -1;
        if (!allowed) begin
          batch.push_back(make_event(EV_OUTSIDE, addr, '0));
        end else begin
          for (int i = 0; i < int'(used_cnt); i++) begin
            if (slot < 0 && entry_addr[i] == addr) slot = i;
          end
          if (slot >= 0) begin
            // a down host stays down until the next scan
            entry_seen[slot] = now;
            batch.push_back(make_event(EV_REFRESHED, addr, now));
          end else if (int'(used_cnt) < tbl_lim) begin
            entry_addr[used_cnt] = addr;
            entry_seen[used_cnt] = now;
            entry_down[used_cnt] = 1'b0;
            used_cnt++;
            batch.push_back(make_event(EV_ADDED, addr, now));
          end else begin
            batch.push_back(make_event(EV_FULL, addr, '0));
          end
        end
      end else begin
        for (int i = 0; i < int'(used_cnt); i++) begin
          diff = now - entry_seen[i];
          if (entry_down[i]) begin
            if (diff < limit) begin
              entry_down[i] = 1'b0;
              if (down_cnt > 0) down_cnt--;
              batch.push_back(make_event(EV_BACK, entry_addr[i], entry_seen[i]));
            end
          end else if (diff >= limit) begin
            entry_down[i] = 1'b1;
            down_cnt++;
            batch.push_back(make_event(EV_DOWN, entry_addr[i], entry_seen[i]));
          end
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) expected_events.push_back(batch[k]);
    endfunction

    function void check_word(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                             logic [TIME_W-1:0] seen, logic [CNT_W-1:0] down_total,
                             logic [CNT_W-1:0] tracked_total, logic last);
      event_word_t exp_w;
      if (expected_events.size() == 0) begin
        $error("unexpected event word: event_kind %0d event_addr %h", kind, addr);
        fail_count++;
        return;
      end
      exp_w = expected_events.pop_front();
      if (kind !== exp_w.kind) begin
        $error("event_kind: expected %0d, got %0d", exp_w.kind, kind);
        fail_count++;
      end
      if (addr !== exp_w.addr) begin
        $error("event_addr: expected %h, got %h", exp_w.addr, addr);
        fail_count++;
      end
      if (seen !== exp_w.seen) begin
        $error("last_seen: expected %h, got %h", exp_w.seen, seen);
        fail_count++;
      end
      if (down_total !== exp_w.down_total) begin
        $error("down_total: expected %0d, got %0d", exp_w.down_total, down_total);
        fail_count++;
      end
      if (tracked_total !== exp_w.tracked_total) begin
        $error("tracked_total: expected %0d, got %0d", exp_w.tracked_total, tracked_total);
        fail_count++;
      end
      if (last !== exp_w.last) begin
        $error("last: expected %0d, got %0d", exp_w.last, last);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  clt_req_if req_if ();
  clt_evt_if evt_if ();
  clt_cfg_if cfg_if ();

  client_liveness_tracker DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (evt_if),
    .cfg_i  (cfg_if)
  );

  liveness_scoreboard tracker_model = new();

  bit                hold_req;
  bit                calm;
  int unsigned       idle_cycles;
  logic [TIME_W-1:0] clock_now;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // End the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (evt_if.valid === 1'b1 && evt_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic mode, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.mode      <= mode;
    req_if.host_addr <= addr;
    req_if.now_time  <= now;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    tracker_model.note_item(mode, addr, now);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CDATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    tracker_model.note_config(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_all(logic [CDATA_W-1:0] expire, logic [CDATA_W-1:0] max_hosts,
                             logic [CDATA_W-1:0] net_count,
                             logic [CDATA_W-1:0] base0, logic [CDATA_W-1:0] mask0,
                             logic [CDATA_W-1:0] base1, logic [CDATA_W-1:0] mask1);
    write_reg(CFG_EXPIRE, expire);
    write_reg(CFG_MAX_CLIENTS, max_hosts);
    write_reg(CFG_NET_COUNT, net_count);
    write_reg(CFG_NET0_BASE, base0);
    write_reg(CFG_NET0_MASK, mask0);
    write_reg(CFG_NET1_BASE, base1);
    write_reg(CFG_NET1_MASK, mask1);
  endtask

  // Drop valid, wait for every expected word, then let a silent scan finish.
  task automatic settle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (tracker_model.expected_events.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] pick_host();
    int unsigned       roll;
    int unsigned       k;
    logic [ADDR_W-1:0] r;
    roll = $urandom_range(0, 99);
    k    = $urandom_range(0, 1);
    r    = $urandom();
    if (roll < 55 && tracker_model.used_cnt > 0)
      return tracker_model.entry_addr[$urandom_range(0, tracker_model.used_cnt - 1)];
    if (roll < 85)
      return (tracker_model.net_base[k] & tracker_model.net_mask[k]) |
             (r & ~tracker_model.net_mask[k]);
    return r;
  endfunction

  function automatic logic [CDATA_W-1:0] pick_mask();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFF00_0000;
      3:       return 32'hFFFF_FF00;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stalls, one long hold on request.
  initial begin
    int unsigned stall;
    evt_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        evt_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      evt_if.ready <= 1'b1;
      do @(posedge clk); while (evt_if.valid !== 1'b1);
      tracker_model.check_word(evt_if.event_kind, evt_if.event_addr, evt_if.last_seen,
                               evt_if.down_total, evt_if.tracked_total, evt_if.last);
    end
  end

  initial begin
    logic [CDATA_W-1:0] expire;
    logic [CDATA_W-1:0] max_hosts;
    logic [CDATA_W-1:0] net_count;
    int unsigned        roll;
    req_if.valid     <= 1'b0;
    req_if.mode      <= 1'b0;
    req_if.host_addr <= '0;
    req_if.now_time  <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_EXPIRE;
    cfg_if.data      <= '0;
    hold_req    = 1'b0;
    calm        = 1'b0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: append, refresh, scan with nothing to do, down, refresh of a
    // down host, back up.
    send_item(1'b0, 32'h0000_0000, 32'd0);
    send_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 32'h0000_0000, 32'd100);
    send_item(1'b1, 32'h0000_0000, 32'd100);
    send_item(1'b1, 32'hFFFF_FFFF, 32'd3700);
    send_item(1'b0, 32'hFFFF_FFFF, 32'd3700);
    send_item(1'b1, 32'h5A5A_5A5A, 32'd3700);
    settle();

    // Zero expiry, full table, both filters with a count of three.
    program_all(32'd0, 32'd2, 32'd3, 32'h0A00_0000, 32'hFF00_0000,
                32'hC0A8_0000, 32'hFFFF_0000);
    send_item(1'b0, 32'h0A01_0203, 32'd3700);
    send_item(1'b0, 32'h0102_0304, 32'd3700);
    send_item(1'b0, 32'hC0A8_0101, 32'd3700);
    send_item(1'b1, 32'h0000_0000, 32'd3700);
    settle();

    // Longest normal expiry, table size above the cap, first filter only.
    program_all(32'd1440, 32'd127, 32'd1, 32'h0A00_0000, 32'hFF00_0000,
                32'hC0A8_0000, 32'hFFFF_0000);
    send_item(1'b0, 32'hC0A8_0101, 32'd4000);
    send_item(1'b0, 32'h0A00_0001, 32'd5000);
    send_item(1'b1, 32'h0000_0000, 32'd91400);
    settle();

    program_all(32'd1, 32'd64, 32'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(1'b0, 32'h0000_0000, 32'd91400);
    send_item(1'b0, 32'hFFFF_FFFF, 32'd91400);
    send_item(1'b1, 32'h0000_0000, 32'd91400);
    settle();

    // No usable entries: new hosts are refused, known ones still refresh.
    program_all(32'd1, 32'd0, 32'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(1'b0, 32'h1234_5678, 32'd91410);
    send_item(1'b0, 32'h0000_0000, 32'd91420);
    settle();

    clock_now = 32'd91420;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 7))
        0:       expire = 32'd0;
        1:       expire = 32'd2047;
        2:       expire = 32'd1440;
        3:       expire = 32'd1;
        default: expire = $urandom_range(1, 4);
      endcase
      if (p == 0) expire = 32'd1;
      if (p == PHASES - 1) expire = 32'd2047;
      case ($urandom_range(0, 7))
        0:       max_hosts = 32'd0;
        1:       max_hosts = 32'd127;
        2:       max_hosts = $urandom_range(1, 63);
        3:       max_hosts = 32'd65;
        default: max_hosts = 32'd64;
      endcase
      if (p < 2) max_hosts = 32'd64;
      net_count = ($urandom_range(0, 99) < 50) ? 32'd0 : $urandom_range(1, 3);
      program_all(expire, max_hosts, net_count, $urandom(), pick_mask(),
                  $urandom(), pick_mask());
      calm = (p == 3);
      for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        if (p == 1 && k == 4) hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 4) clock_now = $urandom();
        else if (roll < 14) clock_now += $urandom_range(0, 130000);
        else clock_now += $urandom_range(0, 120);
        if ($urandom_range(0, 99) < 15) send_item(1'b1, $urandom(), clock_now);
        else send_item(1'b0, pick_host(), clock_now);
      end
      settle();
    end
    calm = 1'b0;

    if (tracker_model.expected_events.size() != 0) begin
      $error("%0d expected event words never arrived", tracker_model.expected_events.size());
      tracker_model.fail_count++;
    end
    if (tracker_model.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
